// ----- rtl/hpt_pkg.sv -----
// Shared types and constants of the homogeneous point transform.
package hpt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_BITS      = 32;

    typedef enum logic {
        OP_LOAD      = 1'b0,
        OP_TRANSFORM = 1'b1
    } opcode_t;

    typedef enum logic {
        ORIENT_ROW = 1'b0,
        ORIENT_COL = 1'b1
    } orient_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_zero;
    } out_t;

endpackage

// ----- rtl/homogeneous_point_transform.sv -----
// Top level: pipelined 4x4 homogeneous transform with perspective divide.
//
// Each transform beat extends (x, y, z) with w = 1.0, multiplies it by the
// stored 4x4 matrix (row vector times matrix when orientation is 0, matrix
// times column vector when it is 1) and divides x, y and z by the rounded w.
// Load beats write one matrix entry and produce no result; a load takes
// effect for every transform beat accepted after it. The pipeline accepts
// one beat per clock when not stalled, and holds 36 register stages: products, rounded sums,
// divide setup, 32 restoring divide stages (one quotient bit per stage,
// shared by nothing, three lanes side by side) and the output register.
// The sustained rate is one point per cycle when the output is not stalled,
// set by the fully pipelined divider. Each stage advances whenever
// the stage after it is empty or moving, so bubbles collapse under
// back-pressure. A zero w gives zero outputs with w_zero set; overflow
// saturates to the 32-bit signed range. Values are signed fixed point with
// FRAC_BITS fraction bits (8 to 24).
module homogeneous_point_transform #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  hpt_pkg::in_t s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output hpt_pkg::out_t m_data
);
    import hpt_pkg::*;

    localparam int DS = DIV_BITS;
    localparam int NS = DS + 4;      // products, sums, setup, divide, output
    localparam int RW = 65;          // remainder width, holds d << 32
    localparam int SW = 66;          // exact four-term sum width

    // Pipeline control: valid per stage, advance when the next one frees.
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] rdy;

    always_comb begin
        rdy[NS-1] = !vld_reg[NS-1] || m_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_ready = rdy[0];

    logic accept;
    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (rdy[i]) begin
                    if (i == 0) begin
                        vld_reg[i] <= accept && (s_data.opcode == OP_TRANSFORM);
                    end else begin
                        vld_reg[i] <= vld_reg[i-1];
                    end
                end
            end
        end
    end

    // Configuration and matrix store.
    orient_t orientation_reg;
    logic signed [31:0] mat_reg [16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orientation_reg <= ORIENT_ROW;
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                orientation_reg <= orient_t'(cfg_wdata);
            end
            if (accept && s_data.opcode == OP_LOAD) begin
                mat_reg[s_data.entry_index] <= s_data.entry_value;
            end
        end
    end

    // Stage 1: twelve exact products plus the translation term per component.
    logic signed [31:0] vec [3];
    logic signed [63:0] prod_next [4][3];
    logic signed [31:0] bias_next [4];
    logic signed [63:0] prod_reg  [4][3];
    logic signed [31:0] bias_reg  [4];

    assign vec[0] = s_data.point_x;
    assign vec[1] = s_data.point_y;
    assign vec[2] = s_data.point_z;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[c][k] = 64'(vec[k]) * ((orientation_reg == ORIENT_COL)
                                  ? 64'(mat_reg[c*4+k]) : 64'(mat_reg[k*4+c]));
            end
            bias_next[c] = (orientation_reg == ORIENT_COL) ? mat_reg[c*4+3]
                                                          : mat_reg[12+c];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            prod_reg <= prod_next;
            bias_reg <= bias_next;
        end
    end

    // Stage 2: exact sum, round half up, saturate.
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] SMAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SMIN = -SW'(64'sd2147483648);

    logic signed [SW-1:0] sum   [4];
    logic signed [SW-1:0] shf   [4];
    logic signed [31:0]   comp_next [4];
    logic signed [31:0]   comp_reg  [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum[c] = SW'(prod_reg[c][0]) + SW'(prod_reg[c][1]) + SW'(prod_reg[c][2])
                   + (SW'(bias_reg[c]) <<< FRAC_BITS) + HALF;
            shf[c] = sum[c] >>> FRAC_BITS;
            if (shf[c] > SMAX) begin
                comp_next[c] = 32'sh7fffffff;
            end else if (shf[c] < SMIN) begin
                comp_next[c] = 32'sh80000000;
            end else begin
                comp_next[c] = shf[c][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            comp_reg <= comp_next;
        end
    end

    // Stage 3: divide setup. Numerator |c| << F plus half the divisor;
    // flag quotients of 2^32 or more for saturation up front.
    logic [31:0]   ud;
    logic [31:0]   uc [3];
    logic [RW-1:0] num [3];
    logic          wz_next;

    logic [RW-1:0] rem_reg [DS+1][3];
    logic [31:0]   quo_reg [DS+1][3];
    logic          neg_reg [DS+1][3];
    logic          sat_reg [DS+1][3];
    logic [31:0]   den_reg [DS+1];
    logic          wz_reg  [DS+1];

    assign ud      = comp_reg[3][31] ? 32'(-comp_reg[3]) : 32'(comp_reg[3]);
    assign wz_next = (comp_reg[3] == '0);

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            uc[l]  = comp_reg[l][31] ? 32'(-comp_reg[l]) : 32'(comp_reg[l]);
            num[l] = (RW'(uc[l]) << FRAC_BITS) + RW'(ud >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            den_reg[0] <= ud;
            wz_reg[0]  <= wz_next;
            for (int l = 0; l < 3; l++) begin
                rem_reg[0][l] <= num[l];
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= (comp_reg[l] != '0) && (comp_reg[l][31] != comp_reg[3][31]);
                sat_reg[0][l] <= num[l] >= (RW'(ud) << DS);
            end
        end
    end

    // Divide stages: one quotient bit per stage, most significant first.
    for (genvar g = 0; g < DS; g++) begin : g_div
        localparam int B = DS - 1 - g;
        logic [RW-1:0] trial [3];

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                trial[l] = RW'(den_reg[g]) << B;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[3+g]) begin
                den_reg[g+1] <= den_reg[g];
                wz_reg[g+1]  <= wz_reg[g];
                for (int l = 0; l < 3; l++) begin
                    neg_reg[g+1][l] <= neg_reg[g][l];
                    sat_reg[g+1][l] <= sat_reg[g][l];
                    if (rem_reg[g][l] >= trial[l]) begin
                        rem_reg[g+1][l]    <= rem_reg[g][l] - trial[l];
                        quo_reg[g+1][l]    <= quo_reg[g][l] | (32'd1 << B);
                    end else begin
                        rem_reg[g+1][l]    <= rem_reg[g][l];
                        quo_reg[g+1][l]    <= quo_reg[g][l];
                    end
                end
            end
        end
    end

    // Output stage: clip, apply sign, force zero on w == 0.
    logic signed [31:0] res [3];
    out_t out_next;
    out_t out_reg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (neg_reg[DS][l]) begin
                if (sat_reg[DS][l] || quo_reg[DS][l] > 32'h80000000) begin
                    res[l] = 32'sh80000000;
                end else begin
                    res[l] = -$signed(quo_reg[DS][l]);
                end
            end else begin
                if (sat_reg[DS][l] || quo_reg[DS][l] > 32'h7fffffff) begin
                    res[l] = 32'sh7fffffff;
                end else begin
                    res[l] = $signed(quo_reg[DS][l]);
                end
            end
        end
        out_next.w_zero = wz_reg[DS];
        out_next.out_x  = wz_reg[DS] ? '0 : res[0];
        out_next.out_y  = wz_reg[DS] ? '0 : res[1];
        out_next.out_z  = wz_reg[DS] ? '0 : res[2];
    end

    always_ff @(posedge aclk) begin
        if (rdy[NS-1]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vld_reg[NS-1];
    assign m_data  = out_reg;

endmodule

// ----- rtl/hpt_checker.sv -----
// Port-level checks of the homogeneous point transform, bound to the top.
module hpt_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input hpt_pkg::out_t m_data
);
    import hpt_pkg::*;

    // Hold a stalled result beat.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Zero all coordinates on a zero w.
    a_wzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.w_zero |->
            m_data.out_x == '0 && m_data.out_y == '0 && m_data.out_z == '0)
        else $error("w_zero beat with nonzero coordinates");

    // Empty the pipeline on reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
